// ===== src/bytewise_block_tea_cipher_defines.svh =====
// Assertion helpers used by the control module.
`ifndef BYTEWISE_BLOCK_TEA_CIPHER_DEFINES_SVH
`define BYTEWISE_BLOCK_TEA_CIPHER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define BTEA_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("btea assertion failed");

// Next-cycle implication, disabled during reset.
`define BTEA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("btea assertion failed");

`endif

// ===== src/btea_pkg.sv =====
package btea_pkg;

    localparam int MAX_LEN = 64;
    localparam int ADDR_W  = $clog2(MAX_LEN);
    localparam int CNT_W   = $clog2(MAX_LEN + 1);

    localparam logic [31:0] DELTA = 32'h9E37_79B9;

    localparam logic [1:0] CFG_KEY_LO = 2'd0;
    localparam logic [1:0] CFG_KEY_HI = 2'd1;
    localparam logic [1:0] CFG_GROUPS = 2'd2;
    localparam logic [1:0] CFG_DIR    = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT0,
        ST_INIT1,
        ST_INIT2,
        ST_RD,
        ST_MIX1,
        ST_MIX2,
        ST_OUT_RD,
        ST_OUT_WAIT,
        ST_OUT_HOLD
    } t_state;

    typedef struct packed {
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic              wr_mix;
        logic [ADDR_W-1:0] wr_addr;
        logic              cap_first;
        logic              cap_second;
        logic              sum_init;
        logic              sum_step;
        logic              mix1;
        logic              mix2;
        logic              x_self;
        logic              out_load;
        logic              out_last;
        logic [ADDR_W-1:0] p;
        logic [6:0]        rounds;
    } t_cmd;

    typedef struct packed {
        logic       dir;
        logic [2:0] groups;
        logic       out_taken;
    } t_stat;

    function automatic logic [31:0] sext8(input logic [7:0] b);
        return {{24{b[7]}}, b};
    endfunction

    function automatic logic [2:0] clamp_groups(input logic [2:0] g);
        logic [2:0] r;
        r = g;
        if (g == 3'd0) r = 3'd1;
        else if (g > 3'd4) r = 3'd4;
        return r;
    endfunction

    // 64 / k for k = 4 * groups
    function automatic logic [6:0] key_rounds(input logic [2:0] g);
        logic [6:0] r;
        case (g)
            3'd1:    r = 7'd16;
            3'd2:    r = 7'd8;
            3'd3:    r = 7'd5;
            default: r = 7'd4;
        endcase
        return r;
    endfunction

    // 64 / n for n in 1..64
    function automatic logic [6:0] len_rounds(input logic [CNT_W-1:0] n);
        logic [6:0] r;
        if (n <= CNT_W'(1))       r = 7'd64;
        else if (n == CNT_W'(2))  r = 7'd32;
        else if (n == CNT_W'(3))  r = 7'd21;
        else if (n == CNT_W'(4))  r = 7'd16;
        else if (n == CNT_W'(5))  r = 7'd12;
        else if (n == CNT_W'(6))  r = 7'd10;
        else if (n == CNT_W'(7))  r = 7'd9;
        else if (n == CNT_W'(8))  r = 7'd8;
        else if (n == CNT_W'(9))  r = 7'd7;
        else if (n == CNT_W'(10)) r = 7'd6;
        else if (n <= CNT_W'(12)) r = 7'd5;
        else if (n <= CNT_W'(16)) r = 7'd4;
        else if (n <= CNT_W'(21)) r = 7'd3;
        else if (n <= CNT_W'(32)) r = 7'd2;
        else                      r = 7'd1;
        return r;
    endfunction

    // p mod (4 * groups), groups already clamped
    function automatic logic [3:0] mod_key(input logic [ADDR_W-1:0] p, input logic [2:0] g);
        logic [7:0] t;
        logic [3:0] r;
        t = 8'(p);
        case (g)
            3'd1: r = {2'b00, t[1:0]};
            3'd2: r = {1'b0, t[2:0]};
            3'd3: begin
                if (t >= 8'd48) t = t - 8'd48;
                if (t >= 8'd24) t = t - 8'd24;
                if (t >= 8'd12) t = t - 8'd12;
                r = t[3:0];
            end
            default: r = t[3:0];
        endcase
        return r;
    endfunction

endpackage

// ===== src/btea_ram.sv =====
module btea_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== src/btea_datapath.sv =====
module btea_datapath (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  btea_pkg::t_cmd        i_cmd,
    output btea_pkg::t_stat       o_stat,
    input  logic [7:0]            i_data_byte,
    input  logic                  i_stall,
    input  logic                  i_cfg_valid,
    input  logic [1:0]            i_cfg_index,
    input  logic [63:0]           i_cfg_data,
    output logic [7:0]            o_out_byte,
    output logic                  o_out_last,
    output logic                  o_valid
);

    logic [63:0] r_key_lo;
    logic [63:0] r_key_hi;
    logic [2:0]  r_groups;
    logic        r_dir;

    logic [31:0] r_sum;
    logic [7:0]  r_x;
    logic [7:0]  r_nb;
    logic [7:0]  r_d;
    logic [31:0] r_ta;
    logic [31:0] r_tb;
    logic [7:0]  r_obyte;
    logic        r_olast;
    logic        r_ovalid;

    logic [7:0]  rd_data;
    logic [7:0]  wr_data;
    logic [2:0]  groups;
    logic [31:0] y;
    logic [31:0] z;
    logic [3:0]  kidx;
    logic [7:0]  kbyte;
    logic [7:0]  mixed;
    logic [7:0]  new_byte;

    assign groups = btea_pkg::clamp_groups(r_groups);

    btea_ram #(
        .WIDTH (8),
        .DEPTH (btea_pkg::MAX_LEN)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.wr_en),
        .i_wr_addr (i_cmd.wr_addr),
        .i_wr_data (wr_data),
        .i_rd_addr (i_cmd.rd_addr),
        .o_rd_data (rd_data)
    );

    always_comb begin
        y        = r_dir ? btea_pkg::sext8(r_nb) : btea_pkg::sext8(rd_data);
        z        = r_dir ? btea_pkg::sext8(rd_data) : btea_pkg::sext8(r_nb);
        kidx     = btea_pkg::mod_key(i_cmd.p, groups) ^ {2'b00, r_sum[3:2]};
        kbyte    = kidx[3] ? r_key_hi[{kidx[2:0], 3'b000} +: 8]
                           : r_key_lo[{kidx[2:0], 3'b000} +: 8];
        mixed    = r_ta[7:0] ^ r_tb[7:0];
        new_byte = r_dir ? (r_x - mixed) : (r_x + mixed);
        wr_data  = i_cmd.wr_mix ? new_byte : i_data_byte;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_lo <= '0;
            r_key_hi <= '0;
            r_groups <= 3'd4;
            r_dir    <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    btea_pkg::CFG_KEY_LO: r_key_lo <= i_cfg_data;
                    btea_pkg::CFG_KEY_HI: r_key_hi <= i_cfg_data;
                    btea_pkg::CFG_GROUPS: r_groups <= i_cfg_data[2:0];
                    btea_pkg::CFG_DIR:    r_dir    <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_cmd.out_load) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.sum_init) begin
            r_sum <= r_dir ? 32'({25'd0, i_cmd.rounds} * btea_pkg::DELTA) : 32'd0;
        end else if (i_cmd.sum_step) begin
            r_sum <= r_dir ? (r_sum - btea_pkg::DELTA) : (r_sum + btea_pkg::DELTA);
        end
        if (i_cmd.cap_first) begin
            if (r_dir) r_nb <= rd_data;
            else       r_x  <= rd_data;
        end
        if (i_cmd.cap_second) begin
            if (r_dir) r_x  <= rd_data;
            else       r_nb <= rd_data;
        end
        if (i_cmd.mix1) begin
            r_ta <= ((z >> 5) ^ (y << 2)) + ((y >> 3) ^ (z << 4));
            r_tb <= (r_sum ^ y) + (btea_pkg::sext8(kbyte) ^ z);
            r_d  <= rd_data;
        end
        if (i_cmd.mix2) begin
            r_nb <= new_byte;
            // a one-byte message is its own neighbor: take the fresh byte
            r_x  <= i_cmd.x_self ? new_byte : r_d;
        end
        if (i_cmd.out_load) begin
            r_obyte <= rd_data;
            r_olast <= i_cmd.out_last;
        end
    end

    assign o_stat.dir       = r_dir;
    assign o_stat.groups    = groups;
    assign o_stat.out_taken = r_ovalid && !i_stall;

    assign o_out_byte = r_obyte;
    assign o_out_last = r_olast;
    assign o_valid    = r_ovalid;

endmodule

// ===== src/btea_ctrl.sv =====
`include "bytewise_block_tea_cipher_defines.svh"

module btea_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  logic            i_last,
    output logic            o_stall,
    input  btea_pkg::t_stat i_stat,
    output btea_pkg::t_cmd  o_cmd
);

    localparam int AW = btea_pkg::ADDR_W;
    localparam int CW = btea_pkg::CNT_W;

    btea_pkg::t_state r_state, n_state;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic [AW-1:0]    r_p, n_p;
    logic [6:0]       r_rounds, n_rounds;
    logic [AW-1:0]    r_i, n_i;

    logic          in_acc;
    logic [AW-1:0] n_last;
    logic          round_end;
    logic [CW-1:0] cnt_inc;
    logic          in_round;

    assign in_acc    = i_valid && (r_state == btea_pkg::ST_IDLE);
    assign n_last    = AW'(r_cnt - CW'(1));
    assign round_end = i_stat.dir ? (r_p == '0) : (r_p == n_last);
    assign cnt_inc   = (r_cnt < CW'(btea_pkg::MAX_LEN)) ? (r_cnt + CW'(1)) : r_cnt;
    assign in_round  = (r_state == btea_pkg::ST_RD) || (r_state == btea_pkg::ST_MIX2);

    always_comb begin
        n_state = r_state;
        case (r_state)
            btea_pkg::ST_IDLE:     if (in_acc && i_last) n_state = btea_pkg::ST_INIT0;
            btea_pkg::ST_INIT0:    n_state = btea_pkg::ST_INIT1;
            btea_pkg::ST_INIT1:    n_state = btea_pkg::ST_INIT2;
            btea_pkg::ST_INIT2:    n_state = btea_pkg::ST_RD;
            btea_pkg::ST_RD:       n_state = btea_pkg::ST_MIX1;
            btea_pkg::ST_MIX1:     n_state = btea_pkg::ST_MIX2;
            btea_pkg::ST_MIX2: begin
                if (round_end && (r_rounds == 7'd1)) n_state = btea_pkg::ST_OUT_RD;
                else                                  n_state = btea_pkg::ST_RD;
            end
            btea_pkg::ST_OUT_RD:   n_state = btea_pkg::ST_OUT_WAIT;
            btea_pkg::ST_OUT_WAIT: n_state = btea_pkg::ST_OUT_HOLD;
            btea_pkg::ST_OUT_HOLD: begin
                if (i_stat.out_taken) begin
                    n_state = (r_i == n_last) ? btea_pkg::ST_IDLE : btea_pkg::ST_OUT_RD;
                end
            end
            default:               n_state = btea_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        n_cnt    = r_cnt;
        n_p      = r_p;
        n_rounds = r_rounds;
        n_i      = r_i;
        case (r_state)
            btea_pkg::ST_IDLE: begin
                if (in_acc) begin
                    n_cnt = cnt_inc;
                    if (i_last) begin
                        n_rounds = 7'd6 + btea_pkg::key_rounds(i_stat.groups)
                                 + btea_pkg::len_rounds(cnt_inc);
                    end
                end
            end
            btea_pkg::ST_INIT0: begin
                n_p = i_stat.dir ? n_last : '0;
                n_i = '0;
            end
            btea_pkg::ST_MIX2: begin
                if (round_end) begin
                    n_p      = i_stat.dir ? n_last : '0;
                    n_rounds = r_rounds - 7'd1;
                end else begin
                    n_p = i_stat.dir ? (r_p - AW'(1)) : (r_p + AW'(1));
                end
            end
            btea_pkg::ST_OUT_HOLD: begin
                if (i_stat.out_taken) begin
                    n_i = r_i + AW'(1);
                    if (r_i == n_last) n_cnt = '0;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        o_cmd        = '0;
        o_cmd.p      = r_p;
        o_cmd.rounds = r_rounds;
        o_stall      = (r_state != btea_pkg::ST_IDLE);
        case (r_state)
            btea_pkg::ST_IDLE: begin
                o_cmd.wr_en   = in_acc && (r_cnt < CW'(btea_pkg::MAX_LEN));
                o_cmd.wr_addr = r_cnt[AW-1:0];
            end
            btea_pkg::ST_INIT0: begin
                o_cmd.rd_addr  = '0;
                o_cmd.sum_init = 1'b1;
            end
            btea_pkg::ST_INIT1: begin
                o_cmd.cap_first = 1'b1;
                o_cmd.rd_addr   = n_last;
            end
            btea_pkg::ST_INIT2: begin
                o_cmd.cap_second = 1'b1;
                o_cmd.sum_step   = !i_stat.dir;
            end
            btea_pkg::ST_RD: begin
                if (i_stat.dir) o_cmd.rd_addr = (r_p == '0) ? n_last : (r_p - AW'(1));
                else            o_cmd.rd_addr = (r_p == n_last) ? '0 : (r_p + AW'(1));
            end
            btea_pkg::ST_MIX1: o_cmd.mix1 = 1'b1;
            btea_pkg::ST_MIX2: begin
                o_cmd.mix2     = 1'b1;
                o_cmd.x_self   = (n_last == '0);
                o_cmd.wr_en    = 1'b1;
                o_cmd.wr_mix   = 1'b1;
                o_cmd.wr_addr  = r_p;
                o_cmd.sum_step = round_end;
            end
            btea_pkg::ST_OUT_RD: o_cmd.rd_addr = r_i;
            btea_pkg::ST_OUT_WAIT: begin
                o_cmd.out_load = 1'b1;
                o_cmd.out_last = (r_i == n_last);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= btea_pkg::ST_IDLE;
            r_cnt    <= '0;
            r_p      <= '0;
            r_rounds <= '0;
            r_i      <= '0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_p      <= n_p;
            r_rounds <= n_rounds;
            r_i      <= n_i;
        end
    end

    `BTEA_ASSERT_IMPL(a_cnt_range, 1'b1, r_cnt <= CW'(btea_pkg::MAX_LEN))
    `BTEA_ASSERT_IMPL(a_p_in_msg, in_round, CW'(r_p) < r_cnt)
    `BTEA_ASSERT_IMPL(a_rounds_live, r_state == btea_pkg::ST_RD, r_rounds != 7'd0)
    `BTEA_ASSERT_NEXT(a_last_starts, in_acc && i_last, r_state == btea_pkg::ST_INIT0)

endmodule

// ===== src/bytewise_block_tea_cipher.sv =====
// Sequence: after the last word, setup states INIT0 to INIT2, then RD, MIX1 and MIX2 per byte
//   per round (rounds = 6 + 64/k + 64/n), then OUT_RD, OUT_WAIT and OUT_HOLD per output word.
// Flow: one input word per cycle while loading; the round loop is bound by the
//   single read port of the message store and the two-stage byte mix.
// Reset: synchronous, active low; clears control and the key, sets groups to 4 and encrypt; store is not cleared.
module bytewise_block_tea_cipher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last,
    // output channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_out_last,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    btea_pkg::t_cmd  cmd;
    btea_pkg::t_stat stat;

    // Configuration is to be written only while idle by the user; the block does not enforce this, so always take it.
    assign o_cfg_ready = 1'b1;

    // Sequence loading, rounds and streaming out.
    btea_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_last  (i_last),
        .o_stall (o_stall),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // Hold the store, key, round sum and the byte mix.
    btea_datapath u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_data_byte (i_data_byte),
        .i_stall     (i_stall),
        .i_cfg_valid (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_byte  (o_out_byte),
        .o_out_last  (o_out_last),
        .o_valid     (o_valid)
    );

endmodule

// ===== bench/tea_checker.sv =====
module tea_checker
    import btea_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [7:0]  i_out_byte,
    input  logic        i_out_last,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);

    logic [7:0]  msg_bytes [MAX_LEN];
    int unsigned msg_len;
    logic [63:0] key_lo, key_hi;
    logic [2:0]  key_grp;
    logic        decrypt;

    logic [7:0]  cipher_bytes_q [$];
    logic        cipher_last_q  [$];

    assign o_pending = cipher_bytes_q.size();

    function automatic logic [31:0] key_word(input int unsigned idx);
        logic [127:0] key;
        logic [7:0]   b;
        key = {key_hi, key_lo};
        b   = key[8*idx +: 8];
        return {{24{b[7]}}, b};
    endfunction

    function automatic logic [31:0] tea_mix(input logic [31:0] y, input logic [31:0] z,
                                            input logic [31:0] sum, input int unsigned p,
                                            input int unsigned e, input int unsigned k);
        logic [31:0] a, b;
        a = ((z >> 5) ^ (y << 2)) + ((y >> 3) ^ (z << 4));
        b = (sum ^ y) + (key_word(((p % k) ^ e) & 15) ^ z);
        return a ^ b;
    endfunction

    // Run the byte-wise block mix over the stored message and queue the bytes out.
    task automatic run_cipher();
        int unsigned n, k, g, rounds, e, p;
        logic [31:0] sum, y, z;
        logic [7:0]  m [MAX_LEN];
        n = msg_len;
        g = key_grp;
        if (g < 1) g = 1;
        if (g > 4) g = 4;
        k = 4 * g;
        rounds = 6 + 64 / k + 64 / n;
        m = msg_bytes;
        if (!decrypt) begin
            sum = '0;
            z = {{24{m[n-1][7]}}, m[n-1]};
            repeat (rounds) begin
                sum += DELTA;
                e = (sum >> 2) & 3;
                for (p = 0; p + 1 < n; p++) begin
                    y = {{24{m[p+1][7]}}, m[p+1]};
                    m[p] = m[p] + 8'(tea_mix(y, z, sum, p, e, k));
                    z = {{24{m[p][7]}}, m[p]};
                end
                y = {{24{m[0][7]}}, m[0]};
                m[n-1] = m[n-1] + 8'(tea_mix(y, z, sum, n - 1, e, k));
                z = {{24{m[n-1][7]}}, m[n-1]};
            end
        end else begin
            sum = rounds * DELTA;
            y = {{24{m[0][7]}}, m[0]};
            repeat (rounds) begin
                e = (sum >> 2) & 3;
                for (p = n - 1; p > 0; p--) begin
                    z = {{24{m[p-1][7]}}, m[p-1]};
                    m[p] = m[p] - 8'(tea_mix(y, z, sum, p, e, k));
                    y = {{24{m[p][7]}}, m[p]};
                end
                z = {{24{m[n-1][7]}}, m[n-1]};
                m[0] = m[0] - 8'(tea_mix(y, z, sum, 0, e, k));
                y = {{24{m[0][7]}}, m[0]};
                sum -= DELTA;
            end
        end
        for (int i = 0; i < n; i++) begin
            cipher_bytes_q.push_back(m[i]);
            cipher_last_q.push_back(i == n - 1);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            key_lo       <= '0;
            key_hi       <= '0;
            key_grp      <= 3'd4;
            decrypt      <= 1'b0;
            msg_len      = 0;
            o_fail_count <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_KEY_LO: key_lo  <= i_cfg_data;
                    CFG_KEY_HI: key_hi  <= i_cfg_data;
                    CFG_GROUPS: key_grp <= i_cfg_data[2:0];
                    CFG_DIR:    decrypt <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_valid && !i_in_stall) begin
                // drop bytes past a full store, keep the count saturated
                if (msg_len < MAX_LEN) begin
                    msg_bytes[msg_len] = i_data_byte;
                    msg_len++;
                end
                if (i_last) begin
                    run_cipher();
                    msg_len = 0;
                end
            end
            if (i_out_valid && !i_out_stall) begin
                if (cipher_bytes_q.size() == 0) begin
                    $error("unexpected output word: out_byte %0h out_last %0b",
                           i_out_byte, i_out_last);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    if (i_out_byte !== cipher_bytes_q[0]) begin
                        $error("out_byte: expected %0h actual %0h",
                               cipher_bytes_q[0], i_out_byte);
                    end
                    if (i_out_last !== cipher_last_q[0]) begin
                        $error("out_last: expected %0b actual %0b",
                               cipher_last_q[0], i_out_last);
                    end
                    if (i_out_byte !== cipher_bytes_q[0] ||
                        i_out_last !== cipher_last_q[0]) begin
                        o_fail_count <= o_fail_count + 1;
                    end
                    void'(cipher_bytes_q.pop_front());
                    void'(cipher_last_q.pop_front());
                end
            end
        end
    end

endmodule

// ===== bench/testbench.sv =====
module testbench;
    import btea_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [7:0]  i_data_byte;
    logic        i_last;
    logic        o_valid;
    logic        i_stall;
    logic [7:0]  o_out_byte;
    logic        o_out_last;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [63:0] i_cfg_data;

    int fail_count;
    int pending;
    int cycle_count;
    int send_idle_pct;   // chance per cycle that the sender holds back
    int recv_stall_pct;  // chance per cycle that the receiver stalls
    int hold_off_len;    // long receiver hold-off, counted down by the receiver

    bytewise_block_tea_cipher i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data_byte (i_data_byte),
        .i_last      (i_last),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out_byte  (o_out_byte),
        .o_out_last  (o_out_last),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    tea_checker i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_in_stall   (o_stall),
        .i_data_byte  (i_data_byte),
        .i_last       (i_last),
        .i_out_valid  (o_valid),
        .i_out_stall  (i_stall),
        .i_out_byte   (o_out_byte),
        .i_out_last   (o_out_last),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: end the run if the block hangs.
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge i_clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT) begin
                $display("testbench: errors");
                $finish;
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off on request so the input backs up.
    initial begin
        i_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_len > 0) begin
                i_stall      <= 1'b1;
                hold_off_len <= hold_off_len - 1;
            end else begin
                i_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    // Offer one word; hold it until accepted, then maybe go idle for a while.
    task automatic send_word(input logic [7:0] b, input logic lst);
        i_valid     <= 1'b1;
        i_data_byte <= b;
        i_last      <= lst;
        do @(posedge i_clk); while (o_stall);
        if ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    task automatic send_message(input int len);
        for (int i = 0; i < len; i++)
            send_word(8'($urandom), i == len - 1);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    // Drain all expected words, then let the block settle before touching registers.
    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic set_key(input logic [63:0] lo, input logic [63:0] hi,
                           input logic [2:0] grp, input logic dir);
        write_reg(CFG_KEY_LO, lo);
        write_reg(CFG_KEY_HI, hi);
        write_reg(CFG_GROUPS, 64'(grp));
        write_reg(CFG_DIR, 64'(dir));
    endtask

    // Mostly short messages; now and then a long one, a full store, or an overflow.
    task automatic random_messages(input int words);
        int sent;
        int len;
        int pick;
        sent = 0;
        while (sent < words) begin
            pick = $urandom_range(99);
            if (pick < 80)      len = $urandom_range(1, 8);
            else if (pick < 95) len = $urandom_range(9, 24);
            else if (pick < 98) len = MAX_LEN;
            else                len = MAX_LEN + $urandom_range(1, 4);
            send_message(len);
            sent += len;
        end
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_data_byte    = '0;
        i_last         = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_index    = CFG_KEY_LO;
        i_cfg_data     = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_off_len   = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset key first, then edge bytes, zeros surviving, both directions.
        send_word(8'h00, 1'b1);
        send_word(8'hFF, 1'b1);
        send_word(8'h80, 1'b0);
        send_word(8'h7F, 1'b1);
        repeat (2) send_word(8'h00, 1'b0);
        send_word(8'h00, 1'b1);
        wait_drained();
        set_key(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 3'd0, 1'b1);
        send_word(8'hFF, 1'b0);
        send_word(8'h01, 1'b0);
        send_word(8'h80, 1'b1);
        send_word(8'h55, 1'b1);
        wait_drained();
        set_key(64'h8040_2010_0804_0201, 64'h0123_4567_89AB_CDEF, 3'd7, 1'b0);
        send_word(8'hAA, 1'b0);
        send_word(8'h55, 1'b0);
        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b1);
        wait_drained();

        // Random phases: each idling mix runs under two key settings.
        for (int ph = 0; ph < 8; ph++) begin
            case (ph / 2)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
                default: begin send_idle_pct = 18; recv_stall_pct = 18; end
            endcase
            set_key({$urandom, $urandom}, {$urandom, $urandom},
                    3'($urandom_range(0, 7)), ph[0]);
            // Stall the output for a long stretch while input keeps coming.
            if (ph == 1) hold_off_len <= 3000;
            random_messages(40);
            wait_drained();
        end

        if (fail_count == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule
